/* sv/imufp_pkg.sv */
// imufp_pkg: constants, quantity codes and the hunt phase type of the imu frame parser
// self-contained, used by imu_frame_parser_unit and imufp_checker

package imufp_pkg;

	// header bytes
	localparam logic [7:0] SyncByte   = 8'h0E;
	localparam logic [7:0] IdControl  = 8'hA1;
	localparam logic [7:0] IdInertial = 8'hA2;

	// body lengths in bytes, not counting the two header bytes
	localparam int BodyControl  = 18;
	localparam int BodyInertial = 42;
	localparam int BodyBits     = BodyInertial * 8;

	// bit offset of the first body byte of a control frame in the collect line
	localparam int ControlAlign = (BodyInertial - BodyControl) * 8;

	// last body index for each kind
	localparam logic [5:0] LastIdxControl  = 6'(BodyControl - 1);
	localparam logic [5:0] LastIdxInertial = 6'(BodyInertial - 1);

	// 0.3048 in Q16, feet to meters
	localparam logic signed [15:0] FeetToMQ16 = 16'sd19976;

	// quantity codes
	localparam logic [3:0] QtyRateX    = 4'd0;
	localparam logic [3:0] QtyAccX     = 4'd3;
	localparam logic [3:0] QtyAccZ     = 4'd5;
	localparam logic [3:0] QtyStatus1  = 4'd6;
	localparam logic [3:0] QtyStatus2  = 4'd7;
	localparam logic [3:0] QtyDangX    = 4'd8;
	localparam logic [3:0] QtyDvelX    = 4'd11;
	localparam logic [3:0] QtyDvelZ    = 4'd13;
	localparam logic [3:0] QtyChecksum = 4'd14;

	typedef enum logic [1:0] {
		PhHunt = 2'd0,
		PhSync = 2'd1,
		PhBody = 2'd2
	} phase_t;

endpackage

/* sv/imu_frame_parser_unit.sv */
// imu_frame_parser_unit: sync/id hunting frame parser with a drain buffer and result register
// depends on imufp_pkg
//
// throughput: one byte per cycle while in_stall is low; results leave at one per cycle when out_stall is low
// order: a frame's closing byte loads the drain buffer, then its results pass through the output
//   register back to back while out_stall is low (9 or 15 in all)
// in_stall rises only on a frame's final byte while the previous frame still drains
// reset (arst_n low, asynchronous): hunting for sync, no frame draining, no result valid

module imu_frame_parser_unit
	import imufp_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	// byte channel
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [7:0]         rx_byte,
	// result channel
	output logic               out_valid,
	input  logic               out_stall,
	output logic               frame_kind,
	output logic [3:0]         quantity,
	output logic signed [47:0] value,
	output logic               last
);

	// ---------------------------------------------------------------
	// collect side: header hunt and body shift line
	// ---------------------------------------------------------------
	phase_t              phase_q, phase_d;
	logic                kind_q;       // kind of the frame being collected
	logic [5:0]          index_q;      // body bytes taken so far
	logic [BodyBits-1:0] line_q;       // body bytes, newest at the top
	logic [BodyBits-1:0] line_full;    // line including the byte in transfer
	logic                in_acc;
	logic                frame_end;    // the byte in the body phase closes the frame
	logic [5:0]          last_idx;

	// ---------------------------------------------------------------
	// drain side: snapshot of a complete body, consumed low byte first
	// ---------------------------------------------------------------
	logic                dbusy_q;
	logic                dkind_q;
	logic [3:0]          qty_q;
	logic [BodyBits-1:0] dbuf_q;
	logic                out_ready;
	logic                load_out;

	// result datapath
	logic                is32;
	logic                is_signed16;
	logic                scaled;
	logic signed [32:0]  raw_s;
	logic signed [48:0]  prod_s;
	logic [47:0]         value_d;
	logic [3:0]          qty_next;

	// output register
	logic                out_valid_q;
	logic                frame_kind_q;
	logic [3:0]          quantity_q;
	logic [47:0]         value_q;
	logic                last_q;

	assign in_acc    = in_valid && !in_stall;
	assign last_idx  = kind_q ? LastIdxInertial : LastIdxControl;
	assign line_full = {rx_byte, line_q[BodyBits-1:8]};

	// next phase
	always_comb begin
		phase_d = phase_q;
		if (in_acc) begin
			unique case (phase_q)
				PhHunt: begin
					phase_d = (rx_byte == SyncByte) ? PhSync : PhHunt;
				end
				PhSync: begin
					if (rx_byte == IdControl || rx_byte == IdInertial) begin
						phase_d = PhBody;
					end else if (rx_byte != SyncByte) begin
						phase_d = PhHunt;
					end
				end
				PhBody: begin
					if (frame_end) begin
						phase_d = PhHunt;
					end
				end
				default: begin
					// unused code acts as hunting
					phase_d = (rx_byte == SyncByte) ? PhSync : PhHunt;
				end
			endcase
		end
	end

	// phase outputs: the closing byte waits while the drain buffer is taken
	always_comb begin
		frame_end = (phase_q == PhBody) && (index_q == last_idx);
		in_stall  = frame_end && dbusy_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PhHunt;
			kind_q  <= 1'b0;
			index_q <= '0;
		end else begin
			phase_q <= phase_d;
			if (in_acc && phase_q == PhSync) begin
				index_q <= '0;
				if (rx_byte == IdControl || rx_byte == IdInertial) begin
					kind_q <= (rx_byte == IdInertial);
				end
			end else if (in_acc && phase_q == PhBody) begin
				index_q <= frame_end ? 6'd0 : index_q + 6'd1;
			end
		end
	end

	// body bytes shift in from the top; no reset needed
	always_ff @(posedge clk) begin
		if (in_acc && phase_q == PhBody) begin
			line_q <= line_full;
		end
	end

	// ---------------------------------------------------------------
	// result datapath: field select, sign handling, unit scaling
	// ---------------------------------------------------------------
	assign is32        = (qty_q >= QtyDangX) && (qty_q <= QtyDvelZ);
	assign is_signed16 = (qty_q < QtyStatus1);
	assign scaled      = ((qty_q >= QtyAccX) && (qty_q <= QtyAccZ))
	                  || ((qty_q >= QtyDvelX) && (qty_q <= QtyDvelZ));

	always_comb begin
		if (is32) begin
			raw_s = $signed({dbuf_q[31], dbuf_q[31:0]});
		end else if (is_signed16) begin
			raw_s = $signed({{17{dbuf_q[15]}}, dbuf_q[15:0]});
		end else begin
			raw_s = $signed({17'd0, dbuf_q[15:0]});
		end
		prod_s  = raw_s * FeetToMQ16;
		value_d = scaled ? prod_s[47:0] : {{15{raw_s[32]}}, raw_s};
		// control frames skip the delta quantities
		if (!dkind_q && qty_q == QtyStatus2) begin
			qty_next = QtyChecksum;
		end else begin
			qty_next = qty_q + 4'd1;
		end
	end

	assign out_ready = !out_valid_q || !out_stall;
	assign load_out  = dbusy_q && out_ready;

	// drain control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dbusy_q <= 1'b0;
			dkind_q <= 1'b0;
			qty_q   <= QtyRateX;
		end else if (in_acc && frame_end) begin
			dbusy_q <= 1'b1;
			dkind_q <= kind_q;
			qty_q   <= QtyRateX;
		end else if (load_out) begin
			qty_q <= qty_next;
			if (qty_q == QtyChecksum) begin
				dbusy_q <= 1'b0;
			end
		end
	end

	// drain buffer: aligned snapshot, then shifted by the field just emitted
	always_ff @(posedge clk) begin
		if (in_acc && frame_end) begin
			dbuf_q <= kind_q ? line_full : (line_full >> ControlAlign);
		end else if (load_out) begin
			dbuf_q <= is32 ? (dbuf_q >> 32) : (dbuf_q >> 16);
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			frame_kind_q <= dkind_q;
			quantity_q   <= qty_q;
			value_q      <= value_d;
			last_q       <= (qty_q == QtyChecksum);
		end
	end

	assign out_valid  = out_valid_q;
	assign frame_kind = frame_kind_q;
	assign quantity   = quantity_q;
	assign value      = $signed(value_q);
	assign last       = last_q;

endmodule

/* sv/imufp_checker.sv */
// imufp_checker: port-level assertions for imu_frame_parser_unit, and its bind
// depends on imufp_pkg

module imufp_checker
	import imufp_pkg::*;
(
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_stall,
	input logic [7:0]         rx_byte,
	input logic               out_valid,
	input logic               out_stall,
	input logic               frame_kind,
	input logic [3:0]         quantity,
	input logic signed [47:0] value,
	input logic               last
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(quantity) && $stable(value)
			&& $stable(frame_kind) && $stable(last))
		else $error("stalled result changed");

	// last marks the checksum and only the checksum
	a_last_chk: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (last == (quantity == QtyChecksum)))
		else $error("last does not match checksum quantity");

	// control frames carry no delta quantities
	a_ctrl_qty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !frame_kind |-> (quantity <= QtyStatus2) || (quantity == QtyChecksum))
		else $error("delta quantity in control frame");

	// a frame's results follow back to back
	a_burst: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !last |=> out_valid)
		else $error("gap inside a frame burst");

endmodule

bind imu_frame_parser_unit imufp_checker u_imufp_checker (.*);
